// ===== sv/triangle_edge_length_stats_unit_assert.svh =====
// Assertion macros for the triangle edge length statistics unit.
`ifndef TRIANGLE_EDGE_LENGTH_STATS_UNIT_ASSERT_SVH
`define TRIANGLE_EDGE_LENGTH_STATS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TELS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define TELS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define TELS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TELS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== sv/tels_pkg.sv =====
// Shared widths, codes and controller/datapath interface types.
package tels_pkg;

    localparam int COORD_BITS   = 24;
    localparam int COUNT_BITS   = 20;
    localparam int LEN_BITS     = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int SSQ_BITS     = 2 * COORD_BITS + 2;
    localparam int REM_BITS     = LEN_BITS + 2;
    localparam int SUM_BITS     = LEN_BITS + 2 + COUNT_BITS;
    localparam int DVS_BITS     = COUNT_BITS + 2;
    localparam int ITER_BITS    = $clog2(SUM_BITS);
    localparam int SQ_AXES      = 3;
    localparam int SQ_LAST_STEP = SQ_AXES + 1;
    localparam int ROOT_STEPS   = LEN_BITS;
    localparam int DIV_STEPS    = SUM_BITS;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_AC = 2'd1;
    localparam logic [1:0] EDGE_BC = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_ROOT  = 7'b0000100,
        S_EDGE  = 7'b0001000,
        S_DINIT = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic       load_in;
        logic [1:0] edge_sel;
        logic [1:0] axis_sel;
        logic       root_clr;
        logic       acc_first;
        logic       acc_en;
        logic       root_step;
        logic       edge_done;
        logic       tri_update;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_stat;

endpackage

// ===== sv/tels_ctrl.sv =====
// Sequencer: steps squares, root iterations, edge updates and the final divide.
module tels_ctrl import tels_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state                r_state, n_state;
    logic [ITER_BITS-1:0]  r_step,  n_step;
    logic [1:0]            r_edge,  n_edge;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_edge  = r_edge;
        o_cmd   = '0;
        o_cmd.edge_sel = r_edge;
        o_cmd.axis_sel = AXIS_X;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_edge  = EDGE_AB;
                    n_step  = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                // abs, square and accumulate overlap; steps after the last axis drain r_abs and r_prod
                if (r_step < ITER_BITS'(SQ_AXES)) begin
                    o_cmd.axis_sel = r_step[1:0];
                end
                o_cmd.root_clr  = (r_step == '0);
                o_cmd.acc_first = (r_step == ITER_BITS'(SQ_AXES - 1));
                o_cmd.acc_en    = (r_step > ITER_BITS'(SQ_AXES - 1));
                if (r_step == ITER_BITS'(SQ_LAST_STEP)) begin
                    n_step  = '0;
                    n_state = S_ROOT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == ITER_BITS'(ROOT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_EDGE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EDGE: begin
                o_cmd.edge_done = 1'b1;
                n_step = '0;
                if (r_edge == EDGE_BC) begin
                    o_cmd.tri_update = 1'b1;
                    n_state = i_stat.last ? S_DINIT : S_IDLE;
                end else begin
                    n_edge  = r_edge + 1'b1;
                    n_state = S_SQ;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == ITER_BITS'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_edge  <= EDGE_AB;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_edge  <= n_edge;
        end
    end

endmodule

// ===== sv/tels_dp.sv =====
// Datapath: squarer, bit-pair square root, running statistics, divider, output beat.
module tels_dp import tels_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cz,
    input  logic                         i_last_triangle,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [LEN_BITS-1:0]          o_mean_length,
    output logic [LEN_BITS-1:0]          o_min_length,
    output logic [LEN_BITS-1:0]          o_max_length,
    output logic [COUNT_BITS-1:0]        o_triangles_seen,
    output logic                         o_overflow
);

    // captured triangle
    logic [COORD_BITS-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_cx, r_cy, r_cz;
    logic                  r_last;

    // squared distance
    logic [COORD_BITS-1:0] r_abs;
    logic [SQ_BITS-1:0]    r_prod;
    logic [SSQ_BITS-1:0]   r_ssq;

    // square root
    logic [REM_BITS-1:0]   r_rem;
    logic [LEN_BITS-1:0]   r_root;

    // running statistics
    logic [SUM_BITS-1:0]   r_sum;
    logic [LEN_BITS-1:0]   r_min;
    logic [LEN_BITS-1:0]   r_max;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_sat;

    // divider
    logic [SUM_BITS-1:0]   r_quo;
    logic [DVS_BITS-1:0]   r_drem;
    logic [DVS_BITS-1:0]   r_dvs;

    // output register
    logic                  r_out_valid;
    logic [LEN_BITS-1:0]   r_mean, r_omin, r_omax;
    logic [COUNT_BITS-1:0] r_ocount;
    logic                  r_osat;

    logic [COORD_BITS-1:0] sel_p, sel_q;
    logic [COORD_BITS:0]   diff, diff_neg;
    logic [REM_BITS-1:0]   rem_sh, trial, rem_sub;
    logic                  root_ge;
    logic [DVS_BITS:0]     drem_sh, drem_sub;
    logic                  div_ge;
    logic                  count_full;

    always_comb begin
        sel_p = r_ax;
        sel_q = r_bx;
        case ({i_cmd.edge_sel, i_cmd.axis_sel})
            {EDGE_AB, AXIS_X}: begin sel_p = r_ax; sel_q = r_bx; end
            {EDGE_AB, AXIS_Y}: begin sel_p = r_ay; sel_q = r_by; end
            {EDGE_AB, AXIS_Z}: begin sel_p = r_az; sel_q = r_bz; end
            {EDGE_AC, AXIS_X}: begin sel_p = r_ax; sel_q = r_cx; end
            {EDGE_AC, AXIS_Y}: begin sel_p = r_ay; sel_q = r_cy; end
            {EDGE_AC, AXIS_Z}: begin sel_p = r_az; sel_q = r_cz; end
            {EDGE_BC, AXIS_X}: begin sel_p = r_bx; sel_q = r_cx; end
            {EDGE_BC, AXIS_Y}: begin sel_p = r_by; sel_q = r_cy; end
            {EDGE_BC, AXIS_Z}: begin sel_p = r_bz; sel_q = r_cz; end
            default: begin sel_p = r_ax; sel_q = r_bx; end
        endcase
    end

    // difference of two coordinates fits one extra bit; its magnitude fits COORD_BITS
    assign diff     = {sel_p[COORD_BITS-1], sel_p} - {sel_q[COORD_BITS-1], sel_q};
    assign diff_neg = ~diff + 1'b1;

    // one result bit per step: bring down two radicand bits, try 4*root+1
    assign rem_sh  = {r_rem[LEN_BITS-1:0], r_ssq[SSQ_BITS-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign root_ge = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    // restoring divide, one quotient bit per step
    assign drem_sh  = {r_drem, r_quo[SUM_BITS-1]};
    assign div_ge   = (drem_sh >= {1'b0, r_dvs});
    assign drem_sub = drem_sh - {1'b0, r_dvs};

    assign count_full = (r_count == {COUNT_BITS{1'b1}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ax   <= i_ax;
            r_ay   <= i_ay;
            r_az   <= i_az;
            r_bx   <= i_bx;
            r_by   <= i_by;
            r_bz   <= i_bz;
            r_cx   <= i_cx;
            r_cy   <= i_cy;
            r_cz   <= i_cz;
            r_last <= i_last_triangle;
        end

        r_abs  <= diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
        r_prod <= r_abs * r_abs;

        if (i_cmd.acc_first) begin
            r_ssq <= {2'b00, r_prod};
        end else if (i_cmd.acc_en) begin
            r_ssq <= r_ssq + {2'b00, r_prod};
        end else if (i_cmd.root_step) begin
            r_ssq <= r_ssq << 2;
        end

        if (i_cmd.root_clr) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rem  <= root_ge ? rem_sub : rem_sh;
            r_root <= {r_root[LEN_BITS-2:0], root_ge};
        end

        if (i_cmd.div_init) begin
            r_quo  <= r_sum;
            r_drem <= '0;
            r_dvs  <= {1'b0, r_count, 1'b0} + {2'b00, r_count};
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_BITS-2:0], div_ge};
            r_drem <= div_ge ? drem_sub[DVS_BITS-1:0] : drem_sh[DVS_BITS-1:0];
        end

        if (i_cmd.out_load) begin
            r_mean   <= r_quo[LEN_BITS-1:0];
            r_omin   <= r_min;
            r_omax   <= r_max;
            r_ocount <= r_count;
            r_osat   <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                // result taken into the output register: start a fresh mesh
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_count <= '0;
                r_sat   <= 1'b0;
            end else begin
                if (i_cmd.edge_done) begin
                    if (r_root < r_min) begin
                        r_min <= r_root;
                    end
                    if (r_root > r_max) begin
                        r_max <= r_root;
                    end
                    if (!count_full) begin
                        r_sum <= r_sum + {{(SUM_BITS - LEN_BITS){1'b0}}, r_root};
                    end
                end
                if (i_cmd.tri_update) begin
                    if (count_full) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_busy = r_out_valid & i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_mean_length    = r_mean;
    assign o_min_length     = r_omin;
    assign o_max_length     = r_omax;
    assign o_triangles_seen = r_ocount;
    assign o_overflow       = r_osat;

endmodule

// ===== sv/triangle_edge_length_stats_unit.sv =====
// Triangle mesh edge length statistics: min, max, mean and count over a mesh.
// One triangle is accepted at a time; o_in_stall stays high until it is through. Per edge,
//   the sequencer runs squaring, the shared bit-pair square root unit and an update step.
// A last triangle then adds a restoring divide before the result beat is valid, and
//   the beat comes later if the output register is still held.
// Synchronous active-low reset clears the sequencer, statistics and output valid.
`include "triangle_edge_length_stats_unit_assert.svh"
module triangle_edge_length_stats_unit import tels_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cz,
    input  logic                         i_last_triangle,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [LEN_BITS-1:0]          o_mean_length,
    output logic [LEN_BITS-1:0]          o_min_length,
    output logic [LEN_BITS-1:0]          o_max_length,
    output logic [COUNT_BITS-1:0]        o_triangles_seen,
    output logic                         o_overflow
);

    t_cmd  cmd;
    t_stat stat;

    tels_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tels_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_ax             (i_ax),
        .i_ay             (i_ay),
        .i_az             (i_az),
        .i_bx             (i_bx),
        .i_by             (i_by),
        .i_bz             (i_bz),
        .i_cx             (i_cx),
        .i_cy             (i_cy),
        .i_cz             (i_cz),
        .i_last_triangle  (i_last_triangle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mean_length    (o_mean_length),
        .o_min_length     (o_min_length),
        .o_max_length     (o_max_length),
        .o_triangles_seen (o_triangles_seen),
        .o_overflow       (o_overflow)
    );

    `TELS_ASSERT(a_stall_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input beat accepted but stall not raised")
    `TELS_ASSERT(a_min_le_max, i_clk, i_rst_n, o_out_valid |-> (o_min_length <= o_max_length), "result minimum exceeds maximum")
    `TELS_ASSERT(a_mean_le_max, i_clk, i_rst_n, o_out_valid |-> (o_mean_length <= o_max_length), "result mean exceeds maximum")
    `TELS_ASSERT_NEVER(a_load_over_held, i_clk, i_rst_n, cmd.out_load && o_out_valid && i_out_stall, "result loaded over a held output beat")

endmodule
